// File: rtl/cssp_pkg.sv
// Shared types, result codes and the named-colour ROM of the colour string parser.
`timescale 1ns / 1ps
package cssp_pkg;

  localparam int ROM_SIZE   = 147;
  localparam int ROM_BYTES  = 24;
  localparam int POS_W      = 7;

  localparam logic [2:0] FORM_SHORT_HEX = 3'd0;
  localparam logic [2:0] FORM_LONG_HEX  = 3'd1;
  localparam logic [2:0] FORM_RGB_FUNC  = 3'd2;
  localparam logic [2:0] FORM_KEYWORD   = 3'd3;
  localparam logic [2:0] FORM_NONE      = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Result of the hex and rgb() syntax path
  typedef struct packed {
    logic        ok;
    logic [23:0] rgb;
    logic [2:0]  form;
  } syn_res_t;

  // Result of the keyword matcher
  typedef struct packed {
    logic        hit;
    logic [23:0] rgb;
  } name_res_t;

  // Names are right-justified: the first character sits in the highest non-zero byte.
  localparam logic [8*ROM_BYTES-1:0] NAME_TEXT [ROM_SIZE] = '{
    "aliceblue", "antiquewhite", "aqua", "aquamarine", "azure", "beige",
    "bisque", "black", "blanchedalmond", "blue", "blueviolet", "brown",
    "burlywood", "cadetblue", "chartreuse", "chocolate", "coral", "cornflowerblue",
    "cornsilk", "crimson", "cyan", "darkblue", "darkcyan", "darkgoldenrod",
    "darkgray", "darkgrey", "darkgreen", "darkkhaki", "darkmagenta", "darkolivegreen",
    "darkorange", "darkorchid", "darkred", "darksalmon", "darkseagreen", "darkslateblue",
    "darkslategray", "darkslategrey", "darkturquoise", "darkviolet", "deeppink",
    "deepskyblue", "dimgray", "dimgrey", "dodgerblue", "firebrick", "floralwhite",
    "forestgreen", "fuchsia", "gainsboro", "ghostwhite", "gold", "goldenrod", "gray",
    "grey", "green", "greenyellow", "honeydew", "hotpink", "indianred", "indigo",
    "ivory", "khaki", "lavender", "lavenderblush", "lawngreen", "lemonchiffon",
    "lightblue", "lightcoral", "lightcyan", "lightgoldenrodyellow", "lightgray",
    "lightgrey", "lightgreen", "lightpink", "lightsalmon", "lightseagreen",
    "lightskyblue", "lightslategray", "lightslategrey", "lightsteelblue",
    "lightyellow", "lime", "limegreen", "linen", "magenta", "maroon",
    "mediumaquamarine", "mediumblue", "mediumorchid", "mediumpurple",
    "mediumseagreen", "mediumslateblue", "mediumspringgreen", "mediumturquoise",
    "mediumvioletred", "midnightblue", "mintcream", "mistyrose", "moccasin",
    "navajowhite", "navy", "oldlace", "olive", "olivedrab", "orange", "orangered",
    "orchid", "palegoldenrod", "palegreen", "paleturquoise", "palevioletred",
    "papayawhip", "peachpuff", "peru", "pink", "plum", "powderblue", "purple", "red",
    "rosybrown", "royalblue", "saddlebrown", "salmon", "sandybrown", "seagreen",
    "seashell", "sienna", "silver", "skyblue", "slateblue", "slategray", "slategrey",
    "snow", "springgreen", "steelblue", "tan", "teal", "thistle", "tomato",
    "turquoise", "violet", "wheat", "white", "whitesmoke", "yellow", "yellowgreen"
  };

  localparam logic [23:0] NAME_RGB [ROM_SIZE] = '{
    24'hf0f8ff, 24'hfaebd7, 24'h00ffff, 24'h7fffd4, 24'hf0ffff, 24'hf5f5dc,
    24'hffe4c4, 24'h000000, 24'hffebcd, 24'h0000ff, 24'h8a2be2, 24'ha52a2a,
    24'hdeb887, 24'h5f9ea0, 24'h7fff00, 24'hd2691e, 24'hff7f50, 24'h6495ed,
    24'hfff8dc, 24'hdc143c, 24'h00ffff, 24'h00008b, 24'h008b8b, 24'hb8860b,
    24'ha9a9a9, 24'ha9a9a9, 24'h006400, 24'hbdb76b, 24'h8b008b, 24'h556b2f,
    24'hff8c00, 24'h9932cc, 24'h8b0000, 24'he9967a, 24'h8fbc8f, 24'h483d8b,
    24'h2f4f4f, 24'h2f4f4f, 24'h00ced1, 24'h9400d3, 24'hff1493, 24'h00bfff,
    24'h696969, 24'h696969, 24'h1e90ff, 24'hb22222, 24'hfffaf0, 24'h228b22,
    24'hff00ff, 24'hdcdcdc, 24'hf8f8ff, 24'hffd700, 24'hdaa520, 24'h808080,
    24'h808080, 24'h008000, 24'hadff2f, 24'hf0fff0, 24'hff69b4, 24'hcd5c5c,
    24'h4b0082, 24'hfffff0, 24'hf0e68c, 24'he6e6fa, 24'hfff0f5, 24'h7cfc00,
    24'hfffacd, 24'hadd8e6, 24'hf08080, 24'he0ffff, 24'hfafad2, 24'hd3d3d3,
    24'hd3d3d3, 24'h90ee90, 24'hffb6c1, 24'hffa07a, 24'h20b2aa, 24'h87cefa,
    24'h778899, 24'h778899, 24'hb0c4de, 24'hffffe0, 24'h00ff00, 24'h32cd32,
    24'hfaf0e6, 24'hff00ff, 24'h800000, 24'h66cdaa, 24'h0000cd, 24'hba55d3,
    24'h9370d8, 24'h3cb371, 24'h7b68ee, 24'h00fa9a, 24'h48d1cc, 24'hc71585,
    24'h191970, 24'hf5fffa, 24'hffe4e1, 24'hffe4b5, 24'hffdead, 24'h000080,
    24'hfdf5e6, 24'h808000, 24'h6b8e23, 24'hffa500, 24'hff4500, 24'hda70d6,
    24'heee8aa, 24'h98fb98, 24'hafeeee, 24'hd87093, 24'hffefd5, 24'hffdab9,
    24'hcd853f, 24'hffc0cb, 24'hdda0dd, 24'hb0e0e6, 24'h800080, 24'hff0000,
    24'hbc8f8f, 24'h4169e1, 24'h8b4513, 24'hfa8072, 24'hf4a460, 24'h2e8b57,
    24'hfff5ee, 24'ha0522d, 24'hc0c0c0, 24'h87ceeb, 24'h6a5acd, 24'h708090,
    24'h708090, 24'hfffafa, 24'h00ff7f, 24'h4682b4, 24'hd2b48c, 24'h008080,
    24'hd8bfd8, 24'hff6347, 24'h40e0d0, 24'hee82ee, 24'hf5deb3, 24'hffffff,
    24'hf5f5f5, 24'hffff00, 24'h9acd32
  };

  // Count the characters of a right-justified name
  function automatic int name_len(logic [8*ROM_BYTES-1:0] text);
    int n;
    n = 0;
    for (int k = 0; k < ROM_BYTES; k++) begin
      if (text[k*8 +: 8] != 8'h00) n = k + 1;
    end
    return n;
  endfunction

  // Character at a given index from the start of the name, zero past its end
  function automatic logic [7:0] name_char(logic [8*ROM_BYTES-1:0] text, int idx);
    int n;
    n = name_len(text);
    if (idx < n) return text[(n-1-idx)*8 +: 8];
    return 8'h00;
  endfunction

endpackage

// File: rtl/cssp_syntax.sv
// Hex and rgb() syntax tracker of the colour string parser.
`timescale 1ns / 1ps
module cssp_syntax (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      last_i,
  input  logic [7:0]                char_i,
  output logic [cssp_pkg::POS_W-1:0] pos_o,
  output cssp_pkg::syn_res_t        res_o
);

  typedef enum logic [2:0] {
    FS_START, FS_HEX, FS_RGBPRE, FS_RGBBODY, FS_OTHER
  } fs_e;

  typedef enum logic [2:0] {
    PH_LEAD, PH_NUM, PH_AFTER, PH_CLOSED, PH_ERR
  } ph_e;

  localparam logic [6:0] POS_MAX = '1;

  fs_e         fs_q, fs_n, fs_d;
  ph_e         ph_q, ph_n, ph_d;
  logic [6:0]  pos_q, pos_d;
  logic [23:0] hex_q, hex_n, hex_d;
  logic [7:0]  comp_q [3];
  logic [7:0]  comp_n [3];
  logic [7:0]  comp_d [3];
  logic [8:0]  num_q, num_n, num_d;
  logic [1:0]  cnt_q, cnt_n, cnt_d;

  logic        is_dig, is_space, hd_ok;
  logic [3:0]  dig, hd;
  logic [12:0] num_x10;
  logic [14:0] pct_x;
  logic [27:0] pct_prod;
  logic [7:0]  pct_v;
  logic        ok_pct, ok_plain;

  always_comb begin
    is_dig   = (char_i >= 8'd48) && (char_i <= 8'd57);
    dig      = 4'(char_i - 8'd48);
    is_space = (char_i == 8'h20) || (char_i == 8'h09) || (char_i == 8'h0a) ||
               (char_i == 8'h0d);
    hd_ok    = 1'b1;
    hd       = dig;
    if (is_dig) begin
      hd = dig;
    end else if (char_i >= 8'd65 && char_i <= 8'd70) begin
      hd = 4'(char_i - 8'd55);
    end else if (char_i >= 8'd97 && char_i <= 8'd102) begin
      hd = 4'(char_i - 8'd87);
    end else begin
      hd_ok = 1'b0;
    end

    num_x10  = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {9'd0, dig};
    // 255*v/100 as (255*v*5243) >> 19, exact for v up to 100
    pct_x    = {num_q[6:0], 8'h00} - {8'h00, num_q[6:0]};
    pct_prod = {13'd0, pct_x} * 28'd5243;
    pct_v    = pct_prod[26:19];
    ok_pct   = (cnt_q != 2'd3) && (num_q <= 9'd100);
    ok_plain = (cnt_q != 2'd3) && (num_q <= 9'd255);
  end

  always_comb begin
    fs_n   = fs_q;
    ph_n   = ph_q;
    hex_n  = hex_q;
    comp_n = comp_q;
    num_n  = num_q;
    cnt_n  = cnt_q;
    unique case (fs_q)
      FS_START: begin
        if (char_i == 8'h23) fs_n = FS_HEX;
        else if (char_i == 8'h72) fs_n = FS_RGBPRE;
        else fs_n = FS_OTHER;
      end
      FS_HEX: begin
        if (!hd_ok || pos_q > 7'd6) fs_n = FS_OTHER;
        else hex_n = {hex_q[19:0], hd};
      end
      FS_RGBPRE: begin
        if ((pos_q == 7'd1 && char_i == 8'h67) || (pos_q == 7'd2 && char_i == 8'h62)) begin
          fs_n = FS_RGBPRE;
        end else if (pos_q == 7'd3 && char_i == 8'h28) begin
          fs_n = FS_RGBBODY;
          ph_n = PH_LEAD;
        end else begin
          fs_n = FS_OTHER;
        end
      end
      FS_RGBBODY: begin
        unique case (ph_q)
          PH_LEAD: begin
            if (is_dig) begin
              num_n = {5'd0, dig};
              ph_n  = PH_NUM;
            end else if (!is_space) begin
              ph_n = PH_ERR;
            end
          end
          PH_NUM: begin
            priority if (is_dig) begin
              num_n = (num_x10 > 13'd256) ? 9'd256 : num_x10[8:0];
            end else if (char_i == 8'h25) begin
              if (ok_pct) begin
                comp_n[cnt_q] = pct_v;
                cnt_n = cnt_q + 2'd1;
                ph_n  = PH_AFTER;
              end else begin
                ph_n = PH_ERR;
              end
            end else if (is_space) begin
              if (ok_plain) begin
                comp_n[cnt_q] = num_q[7:0];
                cnt_n = cnt_q + 2'd1;
                ph_n  = PH_AFTER;
              end else begin
                ph_n = PH_ERR;
              end
            end else if (char_i == 8'h2c) begin
              if (ok_plain && cnt_q < 2'd2) begin
                comp_n[cnt_q] = num_q[7:0];
                cnt_n = cnt_q + 2'd1;
                ph_n  = PH_LEAD;
              end else begin
                ph_n = PH_ERR;
              end
            end else if (char_i == 8'h29) begin
              if (ok_plain && cnt_q == 2'd2) begin
                comp_n[cnt_q] = num_q[7:0];
                cnt_n = cnt_q + 2'd1;
                ph_n  = PH_CLOSED;
              end else begin
                ph_n = PH_ERR;
              end
            end else begin
              ph_n = PH_ERR;
            end
          end
          PH_AFTER: begin
            priority if (char_i == 8'h2c) begin
              ph_n = (cnt_q < 2'd3) ? PH_LEAD : PH_ERR;
            end else if (char_i == 8'h29) begin
              ph_n = (cnt_q == 2'd3) ? PH_CLOSED : PH_ERR;
            end else if (!is_space) begin
              ph_n = PH_ERR;
            end
          end
          default: ph_n = PH_ERR;
        endcase
      end
      default: fs_n = FS_OTHER;
    endcase
  end

  // Result of the string, from the state after this character
  always_comb begin
    res_o.ok   = 1'b0;
    res_o.rgb  = '0;
    res_o.form = cssp_pkg::FORM_NONE;
    if (fs_n == FS_HEX && pos_q == 7'd3) begin
      res_o.ok   = 1'b1;
      res_o.rgb  = {hex_n[11:8], hex_n[11:8], hex_n[7:4], hex_n[7:4],
                    hex_n[3:0], hex_n[3:0]};
      res_o.form = cssp_pkg::FORM_SHORT_HEX;
    end else if (fs_n == FS_HEX && pos_q == 7'd6) begin
      res_o.ok   = 1'b1;
      res_o.rgb  = hex_n;
      res_o.form = cssp_pkg::FORM_LONG_HEX;
    end else if (fs_n == FS_RGBBODY && ph_n == PH_CLOSED) begin
      res_o.ok   = 1'b1;
      res_o.rgb  = {comp_n[0], comp_n[1], comp_n[2]};
      res_o.form = cssp_pkg::FORM_RGB_FUNC;
    end
  end

  // Return to the start of a string after its final character
  always_comb begin
    if (last_i) begin
      fs_d   = FS_START;
      ph_d   = PH_LEAD;
      pos_d  = '0;
      hex_d  = '0;
      comp_d = '{default: '0};
      num_d  = '0;
      cnt_d  = '0;
    end else begin
      fs_d   = fs_n;
      ph_d   = ph_n;
      pos_d  = (pos_q == POS_MAX) ? POS_MAX : pos_q + 7'd1;
      hex_d  = hex_n;
      comp_d = comp_n;
      num_d  = num_n;
      cnt_d  = cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FS_START;
      ph_q   <= PH_LEAD;
      pos_q  <= '0;
      hex_q  <= '0;
      comp_q <= '{default: '0};
      num_q  <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      fs_q   <= fs_d;
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      hex_q  <= hex_d;
      comp_q <= comp_d;
      num_q  <= num_d;
      cnt_q  <= cnt_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// File: rtl/cssp_names.sv
// Keyword matcher: one candidate flag per named colour, narrowed a character at a time.
`timescale 1ns / 1ps
module cssp_names #(
  parameter int NAME_COUNT   = 147,
  parameter int MAX_NAME_LEN = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       last_i,
  input  logic [7:0]                 char_i,
  input  logic [cssp_pkg::POS_W-1:0] pos_i,
  output cssp_pkg::name_res_t        res_o
);

  logic [NAME_COUNT-1:0] cand_q, cand_d, keep, hit;
  logic                  in_len;

  assign in_len = pos_i < cssp_pkg::POS_W'(MAX_NAME_LEN);

  for (genvar i = 0; i < NAME_COUNT; i++) begin : g_name
    localparam int LEN = cssp_pkg::name_len(cssp_pkg::NAME_TEXT[i]);
    logic [7:0] chars [cssp_pkg::ROM_BYTES];
    for (genvar j = 0; j < cssp_pkg::ROM_BYTES; j++) begin : g_chr
      assign chars[j] = cssp_pkg::name_char(cssp_pkg::NAME_TEXT[i], j);
    end
    assign keep[i] = cand_q[i] && in_len && (pos_i < cssp_pkg::POS_W'(LEN)) &&
                     (chars[pos_i[4:0]] == char_i);
    assign hit[i]  = keep[i] && (pos_i == cssp_pkg::POS_W'(LEN - 1));
  end

  // Names are distinct, so at most one entry ends on this character
  always_comb begin
    res_o.hit = |hit;
    res_o.rgb = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (hit[i]) res_o.rgb = res_o.rgb | cssp_pkg::NAME_RGB[i];
    end
  end

  assign cand_d = last_i ? '1 : keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '1;
    end else if (step_i) begin
      cand_q <= cand_d;
    end
  end

endmodule

// File: rtl/css_color_string_parser.sv
// Top level of the colour string parser: input handshake, result register, form select.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i / in_stall_o   character_i, last_i
//   out      out  out_valid_o / out_stall_i valid_res_o, argb_o, form_o
//
// One character is taken per cycle while the input is not stalled; the result of a
// string appears in the output register in the cycle after its last character is taken.
// The rate is set by the single result register: input stalls only while a
// result waits there under a downstream stall.
// Reset returns the parser to the start of a string and empties the result register.
`timescale 1ns / 1ps
module css_color_string_parser #(
  parameter int NAME_COUNT   = 147,
  parameter int MAX_NAME_LEN = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] argb_o,
  output logic [2:0]  form_o
);

  logic                       accept;
  logic [cssp_pkg::POS_W-1:0] pos;
  cssp_pkg::syn_res_t         syn_res;
  cssp_pkg::name_res_t        name_res;

  logic        out_valid_q, out_valid_d;
  logic        valid_res_q, valid_res_d;
  logic [31:0] argb_q, argb_d;
  logic [2:0]  form_q, form_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  cssp_syntax u_syntax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .last_i (last_i),
    .char_i (character_i),
    .pos_o  (pos),
    .res_o  (syn_res)
  );

  cssp_names #(
    .NAME_COUNT   (NAME_COUNT),
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_names (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .last_i (last_i),
    .char_i (character_i),
    .pos_i  (pos),
    .res_o  (name_res)
  );

  // Hex and rgb() forms take priority over a keyword
  always_comb begin
    if (syn_res.ok) begin
      valid_res_d = 1'b1;
      argb_d      = {cssp_pkg::ALPHA_OPAQUE, syn_res.rgb};
      form_d      = syn_res.form;
    end else if (name_res.hit) begin
      valid_res_d = 1'b1;
      argb_d      = {cssp_pkg::ALPHA_OPAQUE, name_res.rgb};
      form_d      = cssp_pkg::FORM_KEYWORD;
    end else begin
      valid_res_d = 1'b0;
      argb_d      = '0;
      form_d      = cssp_pkg::FORM_NONE;
    end
  end

  always_comb begin
    if (accept && last_i) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the payload with the final character of a request
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      valid_res_q <= valid_res_d;
      argb_q      <= argb_d;
      form_q      <= form_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign argb_o      = argb_q;
  assign form_o      = form_q;

  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while a result is held");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> argb_o == 32'd0 && form_o == cssp_pkg::FORM_NONE)
    else $error("invalid result carries a colour or form");

  a_alpha : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> argb_o[31:24] == cssp_pkg::ALPHA_OPAQUE &&
      form_o != cssp_pkg::FORM_NONE)
    else $error("valid result without opaque alpha or form");

  a_result_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> out_valid_o)
    else $error("final character gave no result");

endmodule

// File: sim/tb.sv
// Self-checking bench for the colour string parser: streams strings, predicts each result.
`timescale 1ns / 1ps
module tb;

  localparam int N_NAMES  = 147;
  localparam int NAME_MAX = 20;
  localparam int WATCHDOG = 2000;

  typedef enum logic [2:0] {ST_START, ST_HEX, ST_RGBPRE, ST_RGBBODY, ST_OTHER} form_st_e;
  typedef enum logic [2:0] {PH_LEAD, PH_NUM, PH_AFTER, PH_CLOSED, PH_ERR} phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] argb;
    logic [2:0]  form;
  } colour_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = 8'h00;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [31:0] argb_o;
  logic [2:0]  form_o;

  css_color_string_parser u_dut (.*);

  always #5 clk_i = ~clk_i;

  char_req_t   pending_chars[$];
  colour_res_t expected_colours[$];
  int          n_errors = 0;
  bit          stim_done = 1'b0;
  int          idle_cycles = 0;

  // Parser state mirror
  form_st_e    p_form;
  int          p_pos;
  logic [23:0] p_hex;
  logic [7:0]  p_comp[3];
  int          p_num;
  int          p_count;
  phase_e      p_phase;
  bit          p_cand[N_NAMES];

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - 48;
    if (c >= "A" && c <= "F") return c - 55;
    if (c >= "a" && c <= "f") return c - 87;
    return -1;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  // Right-justified ROM text: fetch character idx counted from the start
  function automatic logic [7:0] rom_char(int k, int idx);
    logic [8*cssp_pkg::ROM_BYTES-1:0] t;
    int n;
    t = cssp_pkg::NAME_TEXT[k];
    n = 0;
    for (int j = 0; j < cssp_pkg::ROM_BYTES; j++) if (t[j*8 +: 8] != 8'h00) n = j + 1;
    if (idx < n) return t[(n-1-idx)*8 +: 8];
    return 8'h00;
  endfunction

  task automatic parser_clear();
    p_form = ST_START;
    p_pos = 0;
    p_hex = '0;
    p_comp = '{default: 8'h00};
    p_num = 0;
    p_count = 0;
    p_phase = PH_LEAD;
    foreach (p_cand[k]) p_cand[k] = 1'b1;
  endtask

  function automatic bit commit_component(bit pct);
    int v;
    v = p_num;
    if (p_count >= 3) return 0;
    if (pct) begin
      if (v > 100) return 0;
      v = (255 * v) / 100;
    end else if (v > 255) return 0;
    p_comp[p_count] = v[7:0];
    p_count++;
    return 1;
  endfunction

  task automatic rgb_advance(logic [7:0] c);
    bit ok;
    ok = 1;
    case (p_phase)
      PH_LEAD: begin
        if (c >= "0" && c <= "9") begin
          p_num = c - 48;
          p_phase = PH_NUM;
        end else if (!is_ws(c)) ok = 0;
      end
      PH_NUM: begin
        if (c >= "0" && c <= "9") begin
          p_num = p_num * 10 + (c - 48);
          if (p_num > 256) p_num = 256;
        end else if (c == "%") begin
          ok = commit_component(1);
          p_phase = PH_AFTER;
        end else if (is_ws(c)) begin
          ok = commit_component(0);
          p_phase = PH_AFTER;
        end else if (c == ",") begin
          ok = commit_component(0) && p_count < 3;
          p_phase = PH_LEAD;
        end else if (c == ")") begin
          ok = commit_component(0) && p_count == 3;
          p_phase = PH_CLOSED;
        end else ok = 0;
      end
      PH_AFTER: begin
        if (c == ",") begin
          ok = p_count < 3;
          p_phase = PH_LEAD;
        end else if (c == ")") begin
          ok = p_count == 3;
          p_phase = PH_CLOSED;
        end else if (!is_ws(c)) ok = 0;
      end
      default: ok = 0;
    endcase
    if (!ok) p_phase = PH_ERR;
  endtask

  // Advance the mirror by one character; push a colour on the last one
  task automatic predict_colour(char_req_t r);
    int pos, d;
    colour_res_t res;
    pos = p_pos;
    for (int k = 0; k < N_NAMES; k++)
      if (p_cand[k] && (pos >= NAME_MAX || pos >= cssp_pkg::ROM_BYTES ||
          rom_char(k, pos) == 8'h00 || rom_char(k, pos) != r.ch))
        p_cand[k] = 1'b0;
    case (p_form)
      ST_START: p_form = r.ch == "#" ? ST_HEX : r.ch == "r" ? ST_RGBPRE : ST_OTHER;
      ST_HEX: begin
        d = hex_val(r.ch);
        if (d < 0 || pos > 6) p_form = ST_OTHER;
        else p_hex = {p_hex[19:0], d[3:0]};
      end
      ST_RGBPRE: begin
        if (pos == 3 && r.ch == "(") begin
          p_form = ST_RGBBODY;
          p_phase = PH_LEAD;
        end else if (!((pos == 1 && r.ch == "g") || (pos == 2 && r.ch == "b")))
          p_form = ST_OTHER;
      end
      ST_RGBBODY: rgb_advance(r.ch);
      default: p_form = ST_OTHER;
    endcase
    p_pos = pos < 127 ? pos + 1 : 127;
    if (!r.last) return;
    res = '{ok: 1'b0, argb: 32'h0, form: cssp_pkg::FORM_NONE};
    if (p_form == ST_HEX && pos == 3) begin
      res = '{1'b1, {cssp_pkg::ALPHA_OPAQUE, {2{p_hex[11:8]}}, {2{p_hex[7:4]}},
              {2{p_hex[3:0]}}}, cssp_pkg::FORM_SHORT_HEX};
    end else if (p_form == ST_HEX && pos == 6) begin
      res = '{1'b1, {cssp_pkg::ALPHA_OPAQUE, p_hex}, cssp_pkg::FORM_LONG_HEX};
    end else if (p_form == ST_RGBBODY && p_phase == PH_CLOSED) begin
      res = '{1'b1, {cssp_pkg::ALPHA_OPAQUE, p_comp[0], p_comp[1], p_comp[2]},
              cssp_pkg::FORM_RGB_FUNC};
    end else begin
      for (int k = 0; k < N_NAMES; k++)
        if (p_cand[k] && (pos + 1 >= cssp_pkg::ROM_BYTES || rom_char(k, pos + 1) == 8'h00))
        begin
          res = '{1'b1, {cssp_pkg::ALPHA_OPAQUE, cssp_pkg::NAME_RGB[k]},
                  cssp_pkg::FORM_KEYWORD};
          break;
        end
    end
    expected_colours.push_back(res);
    parser_clear();
  endtask

  task automatic queue_string(string s);
    for (int i = 0; i < s.len(); i++)
      pending_chars.push_back('{ch: s[i], last: i == s.len() - 1});
  endtask

  function automatic string rand_hex_digits(int n);
    string s, digs;
    int idx;
    digs = "0123456789abcdefABCDEF";
    s = "";
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(21);
      s = {s, digs.substr(idx, idx)};
    end
    return s;
  endfunction

  function automatic string rand_space();
    string ws[5];
    ws = '{"", " ", "\t", "\n", "\r"};
    return ws[$urandom_range(4)];
  endfunction

  function automatic string rand_component();
    int v;
    case ($urandom_range(5))
      0: v = $urandom_range(300);
      1: return $sformatf("%0d%%", $urandom_range(110));
      2: return $sformatf("%0d", $urandom_range(255));
      3: return $sformatf("%0d%s%%", $urandom_range(100), rand_space());
      default: return $sformatf("%0d", $urandom_range(255));
    endcase
    return $sformatf("%0d", v);
  endfunction

  function automatic string rand_rgb();
    string s;
    int n;
    n = $urandom_range(9) == 0 ? $urandom_range(2, 4) : 3;
    s = "rgb(";
    for (int i = 0; i < n; i++) begin
      s = {s, rand_space(), rand_component(), rand_space()};
      if (i < n - 1) s = {s, ","};
    end
    s = {s, ")"};
    if ($urandom_range(15) == 0) s = {s, " "};
    return s;
  endfunction

  function automatic string rand_noise();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(255)))};
    return s;
  endfunction

  // Name text from the ROM, occasionally damaged
  function automatic string rand_name();
    string s;
    int k, n;
    k = $urandom_range(N_NAMES - 1);
    s = "";
    for (int i = 0; rom_char(k, i) != 8'h00; i++) s = {s, string'(rom_char(k, i))};
    n = $urandom_range(11);
    if (n == 0) s = s.substr(0, s.len() - 2);
    else if (n == 1) s = {s, "x"};
    else if (n == 2) s = s.toupper();
    return s;
  endfunction

  initial begin
    string s;
    int sel;
    parser_clear();
    queue_string("#000");
    queue_string("#FfF");
    queue_string("#a1B2c3");
    queue_string("#ffffff");
    queue_string("#12");
    queue_string("#1234");
    queue_string("#1234567");
    queue_string("#12g");
    queue_string("rgb(0,0,0)");
    queue_string("rgb( 255 ,\t128\n,\r7 )");
    queue_string("rgb(100%,50%,0%)");
    queue_string("rgb(256,0,0)");
    queue_string("rgb(101%,0,0)");
    queue_string("rgb(1,2,3,4)");
    queue_string("rgb(1,2)");
    queue_string("rgb(-1,2,3)");
    queue_string("rgb(,2,3)");
    queue_string("rgb(1 %,2,3)");
    queue_string("rgb(1,2,3)x");
    queue_string(" #fff");
    queue_string("lightgoldenrodyellow");
    queue_string("Red");
    queue_string("mediumspringgreenxxxxxxxxx");
    pending_chars.push_back('{8'h00, 1'b1});
    pending_chars.push_back('{8'hff, 1'b1});
    while (pending_chars.size() < 320) begin
      sel = $urandom_range(9);
      case (sel)
        0, 1: s = {"#", rand_hex_digits($urandom_range(4) == 0 ? $urandom_range(8) : 6)};
        2: s = {"#", rand_hex_digits(3)};
        3, 4, 5: s = rand_rgb();
        6, 7: s = rand_name();
        default: s = rand_noise();
      endcase
      if (s.len() == 0) s = "x";
      queue_string(s);
    end
    // Saturate the position counter once
    for (int i = 0; i < 130; i++) pending_chars.push_back('{"a", i == 129});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Character driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_colour('{character_i, last_i});
        void'(pending_chars.pop_front());
        in_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
      end
      if ((!in_valid_i || !in_stall_o) && pending_chars.size() > 0 && in_gap == 0
          && !(in_valid_i && !in_stall_o && pending_chars.size() == 0)) begin
        in_valid_i  <= 1'b1;
        character_i <= pending_chars[0].ch;
        last_i      <= pending_chars[0].last;
      end else if (!in_valid_i || !in_stall_o) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
      if (pending_chars.size() == 0 && !stim_done) stim_done = 1'b1;
    end
  end

  // Result monitor
  int out_hold = 0;
  always @(posedge clk_i) begin
    colour_res_t exp_c;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_colours.size() == 0) begin
          $error("unexpected result valid_res=%0b argb=%h form=%0d",
                 valid_res_o, argb_o, form_o);
          n_errors++;
        end else begin
          exp_c = expected_colours.pop_front();
          if (valid_res_o !== exp_c.ok) begin
            $error("valid_res: expected %0b, got %0b", exp_c.ok, valid_res_o);
            n_errors++;
          end
          if (argb_o !== exp_c.argb) begin
            $error("argb: expected %h, got %h", exp_c.argb, argb_o);
            n_errors++;
          end
          if (form_o !== exp_c.form) begin
            $error("form: expected %0d, got %0d", exp_c.form, form_o);
            n_errors++;
          end
        end
        out_hold = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
      end
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else out_stall_i <= 1'b0;
    end
  end

  // Watchdog and end of run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni);
    while (!(stim_done && !in_valid_i && expected_colours.size() == 0)
           && idle_cycles < WATCHDOG)
      @(posedge clk_i);
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: errors");
      $finish;
    end else begin
      repeat (20) @(posedge clk_i);
      if (n_errors == 0 && !out_valid_o) $display("tb: clean");
      else $display("tb: errors");
      $finish;
    end
  end

endmodule
